FILE: rtl/core/srp_pkg.sv
package srp_pkg;

  // Fixed field widths of the channels
  localparam int unsigned MoveW    = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [15:0] StartDelayRst   = 16'd3000;
  localparam logic [15:0] MinDelayRst     = 16'd400;
  localparam logic        DirPolarityRst  = 1'b1;
  localparam logic [7:0]  RampDivisorRst  = 8'd5;
  localparam logic [15:0] MinRampStepsRst = 16'd10;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_DELAY    = 3'd0,
    CFG_MIN_DELAY      = 3'd1,
    CFG_DIR_POLARITY   = 3'd2,
    CFG_RAMP_DIVISOR   = 3'd3,
    CFG_MIN_RAMP_STEPS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] start_delay;
    logic [15:0] min_delay;
    logic        dir_polarity;
    logic [7:0]  ramp_divisor;
    logic [15:0] min_ramp_steps;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic tick;
    logic setup;
    logic ramp_take;
    logic div_step;
    logic step_take;
    logic zero_step;
    logic load_move;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic moving;
    logic start_null;
    logic div_done;
    logic need_div;
  } dp_status_t;

endpackage

FILE: rtl/core/srp_if.sv
interface srp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic signed [srp_pkg::MoveW-1:0]   move_steps;

  modport source (output valid, output opcode, output move_steps, input ready);
  modport sink (input valid, input opcode, input move_steps, output ready);
endinterface

interface srp_out_if;
  logic valid;
  logic ready;
  logic step_level;
  logic dir_level;
  logic busy_res;
  logic move_done;

  modport source (output valid, output step_level, output dir_level, output busy_res,
                  output move_done, input ready);
  modport sink (input valid, input step_level, input dir_level, input busy_res,
                input move_done, output ready);
endinterface

interface srp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [srp_pkg::CfgIdxW-1:0]   index;
  logic [srp_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/srp_cfg_regs.sv
module srp_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  srp_cfg_if.sink       cfg_i,
  output srp_pkg::cfg_t cfg_o
);
  import srp_pkg::*;

  cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.start_delay    <= StartDelayRst;
      regs_q.min_delay      <= MinDelayRst;
      regs_q.dir_polarity   <= DirPolarityRst;
      regs_q.ramp_divisor   <= RampDivisorRst;
      regs_q.min_ramp_steps <= MinRampStepsRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_START_DELAY:    regs_q.start_delay    <= cfg_i.data;
        CFG_MIN_DELAY:      regs_q.min_delay      <= cfg_i.data;
        CFG_DIR_POLARITY:   regs_q.dir_polarity   <= cfg_i.data[0];
        CFG_RAMP_DIVISOR:   regs_q.ramp_divisor   <= cfg_i.data[7:0];
        CFG_MIN_RAMP_STEPS: regs_q.min_ramp_steps <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/srp_div.sv
module srp_div #(
  parameter int unsigned NUM_BITS = 24,
  parameter int unsigned DEN_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  output logic                done_o,
  output logic [NUM_BITS-1:0] quo_o
);
  import srp_pkg::*;

  localparam int unsigned CntW = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DEN_BITS-1:0] rem_q, rem_d;
  logic [DEN_BITS-1:0] den_q;
  logic [NUM_BITS-1:0] quo_q;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[NUM_BITS-1]};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/core/srp_datapath.sv
module srp_datapath #(
  parameter int unsigned STEP_BITS  = 24,
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srp_pkg::cfg_t                       cfg_i,
  input  srp_pkg::dp_cmd_t                    cmd_i,
  output srp_pkg::dp_status_t                 status_o,
  input  logic signed [srp_pkg::MoveW-1:0]    move_steps_i,
  output logic                                step_level_o,
  output logic                                dir_level_o,
  output logic                                busy_res_o,
  output logic                                move_done_o
);
  import srp_pkg::*;

  localparam int unsigned SW   = STEP_BITS;
  localparam int unsigned DW   = DELAY_BITS;
  localparam int unsigned CW   = (DW > 16) ? DW : 16;
  localparam int unsigned NW   = (SW > 16) ? SW : 16;
  localparam int unsigned MagW = (SW > MoveW) ? SW : MoveW;
  localparam logic [MagW-1:0] StepMax  = MagW'((64'd1 << SW) - 64'd1);
  localparam logic [CW-1:0]   DelayMax = CW'((64'd1 << DW) - 64'd1);

  logic [DW-1:0] delay_now_q, delay_now_d;
  logic [DW-1:0] delay_step_q, delay_step_d;
  logic [SW-1:0] ramp_len_q, ramp_len_d;
  logic [SW-1:0] total_q, total_d;
  logic [SW-1:0] index_q, index_d;
  logic [DW-1:0] timer_q, timer_d;
  logic          high_q, high_d;
  logic          moving_q, moving_d;
  logic          dir_q, dir_d;
  logic          tick_done;

  logic step_res_q, dir_res_q, busy_res_q, done_res_q;

  // Move setup
  logic [MoveW-1:0] ms_u, mag_raw;
  logic [MagW-1:0]  mag_w;
  logic [SW-1:0]    total_sat;
  logic             neg;
  logic [7:0]       div_eff;

  // Ramp and delay arithmetic
  logic [NW-1:0] quo, min_ramp_w, ramp_a, half_w, ramp_b;
  logic [CW-1:0] sd_c, min_c, diff_c;
  logic [DW-1:0] sd_dw;
  logic          div_start, div_done;
  logic [NW-1:0] div_num;
  logic [SW-1:0] div_den;

  // Tick arithmetic
  logic [DW-1:0] dec_val, inc_val, adj;
  logic [DW:0]   sum;
  logic          in_accel, in_decel, last_step;

  always_comb begin
    ms_u      = move_steps_i;
    neg       = ms_u[MoveW-1];
    mag_raw   = neg ? (~ms_u + MoveW'(1)) : ms_u;
    mag_w     = MagW'(mag_raw);
    total_sat = (mag_w > StepMax) ? '1 : mag_w[SW-1:0];
    div_eff   = (cfg_i.ramp_divisor == 8'd0) ? 8'd1 : cfg_i.ramp_divisor;

    sd_c   = (CW'(cfg_i.start_delay) > DelayMax) ? DelayMax : CW'(cfg_i.start_delay);
    min_c  = CW'(cfg_i.min_delay);
    diff_c = sd_c - min_c;
    sd_dw  = sd_c[DW-1:0];

    min_ramp_w = NW'(cfg_i.min_ramp_steps);
    ramp_a     = (quo < min_ramp_w) ? min_ramp_w : quo;
    half_w     = NW'(total_q >> 1);
    ramp_b     = (ramp_a > half_w) ? half_w : ramp_a;

    div_start = cmd_i.setup || cmd_i.div_step;
    div_num   = cmd_i.setup ? NW'(total_sat) : NW'(diff_c[15:0]);
    div_den   = cmd_i.setup ? SW'(div_eff) : ramp_len_q;
  end

  srp_div #(
    .NUM_BITS (NW),
    .DEN_BITS (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    dec_val   = (delay_step_q > delay_now_q) ? '0 : delay_now_q - delay_step_q;
    sum       = {1'b0, delay_now_q} + {1'b0, delay_step_q};
    inc_val   = sum[DW] ? '1 : sum[DW-1:0];
    in_accel  = (index_q <= ramp_len_q);
    in_decel  = (index_q > (total_q - ramp_len_q));
    last_step = (index_q >= total_q);
    if (in_accel) begin
      adj = (CW'(delay_now_q) > min_c) ? dec_val : delay_now_q;
    end else if (in_decel) begin
      adj = inc_val;
    end else begin
      adj = delay_now_q;
    end
  end

  always_comb begin
    delay_now_d  = delay_now_q;
    delay_step_d = delay_step_q;
    ramp_len_d   = ramp_len_q;
    total_d      = total_q;
    index_d      = index_q;
    timer_d      = timer_q;
    high_d       = high_q;
    moving_d     = moving_q;
    dir_d        = dir_q;
    tick_done    = 1'b0;

    if (cmd_i.tick && moving_q) begin
      if (timer_q > DW'(1)) begin
        timer_d = timer_q - DW'(1);
      end else if (high_q) begin
        high_d  = 1'b0;
        timer_d = delay_now_q;
      end else begin
        delay_now_d = adj;
        if (last_step) begin
          moving_d  = 1'b0;
          timer_d   = '0;
          tick_done = 1'b1;
        end else begin
          index_d = index_q + SW'(1);
          high_d  = 1'b1;
          timer_d = adj;
        end
      end
    end
    if (cmd_i.setup) begin
      total_d = total_sat;
      dir_d   = neg ? ~cfg_i.dir_polarity : cfg_i.dir_polarity;
    end
    if (cmd_i.ramp_take) begin
      ramp_len_d = ramp_b[SW-1:0];
    end
    if (cmd_i.step_take) begin
      delay_step_d = DW'(quo);
    end
    if (cmd_i.zero_step) begin
      delay_step_d = '0;
    end
    if (cmd_i.load_move) begin
      delay_now_d = sd_dw;
      index_d     = SW'(1);
      high_d      = 1'b1;
      timer_d     = sd_dw;
      moving_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_now_q  <= '0;
      delay_step_q <= '0;
      ramp_len_q   <= '0;
      total_q      <= '0;
      index_q      <= '0;
      timer_q      <= '0;
      high_q       <= 1'b0;
      moving_q     <= 1'b0;
      dir_q        <= 1'b0;
    end else begin
      delay_now_q  <= delay_now_d;
      delay_step_q <= delay_step_d;
      ramp_len_q   <= ramp_len_d;
      total_q      <= total_d;
      index_q      <= index_d;
      timer_q      <= timer_d;
      high_q       <= high_d;
      moving_q     <= moving_d;
      dir_q        <= dir_d;
    end
  end

  // Result register shows the levels after the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      step_res_q <= moving_d && high_d;
      dir_res_q  <= dir_d;
      busy_res_q <= moving_d;
      done_res_q <= tick_done;
    end
  end

  assign step_level_o = step_res_q;
  assign dir_level_o  = dir_res_q;
  assign busy_res_o   = busy_res_q;
  assign move_done_o  = done_res_q;

  assign status_o.moving     = moving_q;
  assign status_o.start_null = (ms_u == '0);
  assign status_o.div_done   = div_done;
  assign status_o.need_div   = (ramp_len_q != '0) && (sd_c > min_c);

endmodule

FILE: rtl/core/srp_ctrl.sv
module srp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_opcode_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  srp_pkg::dp_status_t status_i,
  output srp_pkg::dp_cmd_t    cmd_o
);
  import srp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RAMP,
    ST_PREP,
    ST_DIV_STEP,
    ST_LOAD
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  logic    accept;
  dp_cmd_t cmd;

  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    in_ready_o = (state_q == ST_IDLE) && out_free;
    accept     = in_valid_i && in_ready_o;
    state_d    = state_q;
    cmd        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((opcode_e'(in_opcode_i) == OP_START) && !status_i.moving &&
              !status_i.start_null) begin
            cmd.setup = 1'b1;
            state_d   = ST_DIV_RAMP;
          end else begin
            cmd.tick     = (opcode_e'(in_opcode_i) == OP_TICK);
            cmd.out_load = 1'b1;
          end
        end
      end
      ST_DIV_RAMP: begin
        if (status_i.div_done) begin
          cmd.ramp_take = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status_i.need_div) begin
          cmd.div_step = 1'b1;
          state_d      = ST_DIV_STEP;
        end else begin
          cmd.zero_step = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_DIV_STEP: begin
        if (status_i.div_done) begin
          cmd.step_take = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd.load_move = 1'b1;
          cmd.out_load  = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/stepper_trapezoid_ramp_pulser_unit.sv
// Step and direction pulse generator for one stepper axis with a trapezoidal ramp.
// in_i carries items: a tick (opcode 0) advances time by one microsecond, a start
// (opcode 1) launches a move of move_steps signed steps. Every accepted item yields
// exactly one transfer on res_o with the step, direction and busy levels after the
// item, and move_done set on the tick that closes the last step's low phase.
// cfg_i writes the five setup registers by index; it is always ready. It must be written
// only while the block is idle; the block itself does not enforce this.
// A tick, an ignored start (zero count or axis busy) and any start that causes no
// motion are taken back to back, one item per cycle unless the receiver stalls;
// the result is registered and appears in the cycle after the transfer in. A start
// that launches a move runs one or two passes of a shared one-bit-per-cycle divider
// (ramp length, then delay step); in_i takes no new item until the move is loaded,
// and the second pass is skipped when no delay step is needed.
// A one-entry result register parts the two sides: a new item is taken while the
// previous result is still held, as long as it leaves in the same cycle; when the
// receiver stalls, the result holds and in_i stops taking items.
// Reset clears the move state and brings the setup registers to their defaults.
module stepper_trapezoid_ramp_pulser_unit #(
  parameter int unsigned STEP_BITS  = 24,
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srp_in_if.sink     in_i,
  srp_out_if.source  res_o,
  srp_cfg_if.sink    cfg_i
);
  import srp_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Setup registers
  srp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake and start sequencing
  srp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Move state, ramp arithmetic and the result register
  srp_datapath #(
    .STEP_BITS  (STEP_BITS),
    .DELAY_BITS (DELAY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .move_steps_i (in_i.move_steps),
    .step_level_o (res_o.step_level),
    .dir_level_o  (res_o.dir_level),
    .busy_res_o   (res_o.busy_res),
    .move_done_o  (res_o.move_done)
  );

endmodule
